// File: rtl/integer_to_roman_serializer_core_macros.svh
// Assertion macros for the Roman numeral serializer.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef INTEGER_TO_ROMAN_SERIALIZER_CORE_MACROS_SVH
`define INTEGER_TO_ROMAN_SERIALIZER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define I2R_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("i2r assertion failed");
// Next-cycle implication
`define I2R_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("i2r assertion failed");
`else
`define I2R_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define I2R_ASSERT_NXT(lbl, clk, rst_n, a, b)
`endif
`endif

// File: rtl/i2r_pkg.sv
`default_nettype none
package i2r_pkg;

    localparam int VALUE_W  = 12;
    localparam int SYM_W    = 7;
    localparam int MAX_VAL  = 3999;
    localparam int C_THOUSAND = 1000;
    localparam int C_HUNDRED  = 100;
    localparam int C_TEN      = 10;
    localparam int Q_DEPTH  = 4;

    // Pattern slot codes within one decade
    localparam logic [1:0] SLOT_ONE  = 2'd0;
    localparam logic [1:0] SLOT_FIVE = 2'd1;
    localparam logic [1:0] SLOT_TEN  = 2'd2;

    // Decade indexes
    localparam logic [1:0] DEC_ONES  = 2'd0;
    localparam logic [1:0] DEC_TENS  = 2'd1;
    localparam logic [1:0] DEC_HUNDS = 2'd2;
    localparam logic [1:0] DEC_THOUS = 2'd3;

    // Classified item handed from front to back
    typedef struct packed {
        logic            err;
        logic [3:0][3:0] dig;   // dig[3] thousands ... dig[0] ones
    } i2r_item_t;

    // Number of symbols a decimal digit produces
    function automatic logic [2:0] digit_len(input logic [3:0] d);
        logic [2:0] n;
        case (d)
            4'd0:    n = 3'd0;
            4'd1:    n = 3'd1;
            4'd2:    n = 3'd2;
            4'd3:    n = 3'd3;
            4'd4:    n = 3'd2;
            4'd5:    n = 3'd1;
            4'd6:    n = 3'd2;
            4'd7:    n = 3'd3;
            4'd8:    n = 3'd4;
            4'd9:    n = 3'd2;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    // Slot used at a position of a digit's subtractive pattern
    function automatic logic [1:0] digit_slot(input logic [3:0] d, input logic [1:0] pos);
        logic [1:0] s;
        s = SLOT_ONE;
        case (d)
            4'd4:                begin if (pos == 2'd1) s = SLOT_FIVE; end
            4'd5, 4'd6, 4'd7, 4'd8: begin if (pos == 2'd0) s = SLOT_FIVE; end
            4'd9:                begin if (pos == 2'd1) s = SLOT_TEN; end
            default:             s = SLOT_ONE;
        endcase
        return s;
    endfunction

    // ASCII symbol for a decade and slot
    function automatic logic [SYM_W-1:0] decade_sym(input logic [1:0] dec, input logic [1:0] slot);
        logic [SYM_W-1:0] c;
        case (dec)
            DEC_ONES:  c = (slot == SLOT_ONE) ? 7'h49 : (slot == SLOT_FIVE) ? 7'h56 : 7'h58;
            DEC_TENS:  c = (slot == SLOT_ONE) ? 7'h58 : (slot == SLOT_FIVE) ? 7'h4C : 7'h43;
            DEC_HUNDS: c = (slot == SLOT_ONE) ? 7'h43 : (slot == SLOT_FIVE) ? 7'h44 : 7'h4D;
            DEC_THOUS: c = 7'h4D;
            default:   c = 7'h4D;
        endcase
        return c;
    endfunction

    // Highest decade below lim whose digit emits symbols: {found, index}
    function automatic logic [2:0] find_below(input logic [3:0][3:0] dig, input logic [2:0] lim);
        logic       found;
        logic [1:0] idx;
        found = 1'b0;
        idx   = DEC_ONES;
        for (int i = 3; i >= 0; i--) begin
            if (!found && (i < int'(lim)) && (digit_len(dig[i]) != 3'd0)) begin
                found = 1'b1;
                idx   = 2'(i);
            end
        end
        return {found, idx};
    endfunction

endpackage
`default_nettype wire

// File: rtl/i2r_front.sv
`default_nettype none
module i2r_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [i2r_pkg::VALUE_W-1:0]   value,
    input  wire logic                          q_full,
    output logic                               q_push,
    output i2r_pkg::i2r_item_t                 q_item
);
    import i2r_pkg::*;

    // Count of multiples of step not above x (x below ten steps)
    function automatic logic [3:0] digit_of(input logic [9:0] x, input logic [9:0] step);
        logic [3:0] cnt;
        cnt = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if ({4'd0, x} >= 14'(k) * {4'd0, step}) cnt = cnt + 4'd1;
        end
        return cnt;
    endfunction

    logic                v1_reg, v2_reg, v3_reg;
    logic                v1_next, v2_next, v3_next;
    logic [VALUE_W-1:0]  val1_reg;
    logic                err1_reg, err2_reg, err3_reg;
    logic [1:0]          th2_reg, th3_reg;
    logic [9:0]          rem2_reg;
    logic [3:0]          h3_reg;
    logic [6:0]          rem3_reg;
    logic                m1, m2, m3, accept;
    logic [1:0]          th_c;
    logic [9:0]          rem1_c;
    logic [3:0]          h_c, t_c;
    logic [6:0]          rem_h_c;
    logic [6:0]          ones_c;

    // Stage advance chain
    always_comb
    begin
        m3       = v3_reg && !q_full;
        m2       = v2_reg && (!v3_reg || m3);
        m1       = v1_reg && (!v2_reg || m2);
        in_stall = v1_reg && !m1;
        accept   = in_valid && !in_stall;
        v1_next  = accept || (v1_reg && !m1);
        v2_next  = m1 || (v2_reg && !m2);
        v3_next  = m2 || (v3_reg && !m3);
    end

    // Thousands split
    always_comb
    begin
        if (val1_reg >= VALUE_W'(3 * C_THOUSAND))      th_c = 2'd3;
        else if (val1_reg >= VALUE_W'(2 * C_THOUSAND)) th_c = 2'd2;
        else if (val1_reg >= VALUE_W'(C_THOUSAND))     th_c = 2'd1;
        else                                           th_c = 2'd0;
        rem1_c = 10'(val1_reg - VALUE_W'(th_c) * VALUE_W'(C_THOUSAND));
    end

    // Hundreds split
    always_comb
    begin
        h_c     = digit_of(rem2_reg, 10'(C_HUNDRED));
        rem_h_c = 7'(rem2_reg - 10'(h_c) * 10'(C_HUNDRED));
    end

    // Tens and ones on the way into the queue
    always_comb
    begin
        t_c    = digit_of({3'd0, rem3_reg}, 10'(C_TEN));
        ones_c = 7'(rem3_reg - 7'(t_c) * 7'(C_TEN));
        q_push = m3;
        q_item.err    = err3_reg;
        q_item.dig[3] = {2'd0, th3_reg};
        q_item.dig[2] = h3_reg;
        q_item.dig[1] = t_c;
        q_item.dig[0] = ones_c[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            val1_reg <= value;
            err1_reg <= (value == '0) || (value > VALUE_W'(MAX_VAL));
        end
        if (m1)
        begin
            th2_reg  <= th_c;
            rem2_reg <= rem1_c;
            err2_reg <= err1_reg;
        end
        if (m2)
        begin
            th3_reg  <= th2_reg;
            h3_reg   <= h_c;
            rem3_reg <= rem_h_c;
            err3_reg <= err2_reg;
        end
    end

endmodule
`default_nettype wire

// File: rtl/i2r_queue.sv
`default_nettype none
module i2r_queue #(
    parameter int DEPTH = i2r_pkg::Q_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire i2r_pkg::i2r_item_t push_item,
    output logic                    full,
    input  wire logic               pop,
    output logic                    head_valid,
    output i2r_pkg::i2r_item_t      head_item
);
    import i2r_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    i2r_item_t       mem_reg [DEPTH];
    logic [PW-1:0]   wr_reg, rd_reg, wr_next, rd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    // Pointers with explicit wrap
    always_comb
    begin
        full       = (cnt_reg == CW'(DEPTH));
        head_valid = (cnt_reg != '0);
        head_item  = mem_reg[rd_reg];
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        if (push) wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        if (pop)  rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        cnt_next = cnt_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_reg] <= push_item;
    end

endmodule
`default_nettype wire

// File: rtl/i2r_back.sv
`default_nettype none
module i2r_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       q_valid,
    input  wire i2r_pkg::i2r_item_t         q_item,
    output logic                            q_pop,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [i2r_pkg::SYM_W-1:0]       symbol,
    output logic                            error,
    output logic                            last
);
    import i2r_pkg::*;

    logic                busy_reg, busy_next;
    logic                err_reg;
    logic [3:0][3:0]     dig_reg;
    logic [1:0]          dec_reg, pos_reg;
    logic                ov_reg, ov_next;
    logic [SYM_W-1:0]    sym_reg;
    logic                oerr_reg, olast_reg;

    logic                cur_err;
    logic [3:0][3:0]     cur_dig;
    logic [1:0]          cur_dec, cur_pos;
    logic [2:0]          top_c, below_c;
    logic [2:0]          len_c;
    logic                emit, more_here, end_c;
    logic [SYM_W-1:0]    sym_c;
    logic [1:0]          nxt_dec, nxt_pos;

    // Current symbol source: held item, or queue head at its first symbol
    always_comb
    begin
        top_c = find_below(q_item.dig, 3'd4);
        if (busy_reg)
        begin
            cur_err = err_reg;
            cur_dig = dig_reg;
            cur_dec = dec_reg;
            cur_pos = pos_reg;
        end
        else
        begin
            cur_err = q_item.err;
            cur_dig = q_item.dig;
            cur_dec = top_c[1:0];
            cur_pos = 2'd0;
        end
    end

    // Symbol lookup and step to the next position
    always_comb
    begin
        len_c     = digit_len(cur_dig[cur_dec]);
        sym_c     = cur_err ? '0 : decade_sym(cur_dec, digit_slot(cur_dig[cur_dec], cur_pos));
        more_here = ({1'b0, cur_pos} + 3'd1) < len_c;
        below_c   = find_below(cur_dig, {1'b0, cur_dec});
        end_c     = cur_err || (!more_here && !below_c[2]);
        nxt_dec   = more_here ? cur_dec : below_c[1:0];
        nxt_pos   = more_here ? cur_pos + 2'd1 : 2'd0;
        emit      = (busy_reg || q_valid) && (!ov_reg || !out_stall);
        q_pop     = emit && !busy_reg;
        busy_next = emit ? !end_c : busy_reg;
        ov_next   = emit || (ov_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            ov_reg   <= ov_next;
        end
    end

    // Held item and output register
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            sym_reg   <= sym_c;
            oerr_reg  <= cur_err;
            olast_reg <= end_c;
            err_reg   <= cur_err;
            dig_reg   <= cur_dig;
            dec_reg   <= nxt_dec;
            pos_reg   <= nxt_pos;
        end
    end

    assign out_valid = ov_reg;
    assign symbol    = sym_reg;
    assign error     = oerr_reg;
    assign last      = olast_reg;

endmodule
`default_nettype wire

// File: rtl/integer_to_roman_serializer_core.sv
// Integer to Roman numeral serializer. Each input item is a 12-bit value; a value of
// 1 to 3999 yields its Roman numeral as one ASCII symbol item per cycle while out_stall
// is low, most significant first, with last set on the final symbol. Zero or a value
// above 3999 yields one item with symbol 0, error 1 and last 1. A numeral has 1 to 15
// symbols (MMMDCCCLXXXVIII is the longest), all sent on the single symbol port.
// Digit extraction runs in a three-stage front pipeline that feeds a QDEPTH-entry
// queue ahead of the output register, so the front keeps accepting while the back
// serializes, until the queue and the front stages fill.
`default_nettype none
`include "integer_to_roman_serializer_core_macros.svh"
module integer_to_roman_serializer_core #(
    parameter int QDEPTH = i2r_pkg::Q_DEPTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [i2r_pkg::VALUE_W-1:0]  value,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [i2r_pkg::SYM_W-1:0]         symbol,
    output logic                              error,
    output logic                              last
);
    import i2r_pkg::*;

    logic       q_full, q_push, q_pop, q_valid;
    i2r_item_t  push_item, head_item;

    i2r_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .value    (value),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    i2r_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (head_item)
    );

    i2r_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (head_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .symbol    (symbol),
        .error     (error),
        .last      (last)
    );

    // Error items are single and carry no symbol
    `I2R_ASSERT_IMP(a_err_single, clk, rst_n, out_valid && error, last && (symbol == '0))
    // Good symbols are never zero
    `I2R_ASSERT_IMP(a_sym_nonzero, clk, rst_n, out_valid && !error, symbol != '0)
    // Queue is never written when full nor read when empty
    `I2R_ASSERT_IMP(a_q_bounds, clk, rst_n, q_push || q_pop, !(q_push && q_full) && !(q_pop && !q_valid))
    // A stalled output holds its symbol
    `I2R_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(symbol))

endmodule
`default_nettype wire

// File: tb/roman_numeral_checker.sv
`default_nettype none
module roman_numeral_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic                         in_stall,
    input  wire logic [i2r_pkg::VALUE_W-1:0]  value,
    input  wire logic                         out_valid,
    input  wire logic                         out_stall,
    input  wire logic [i2r_pkg::SYM_W-1:0]    symbol,
    input  wire logic                         error,
    input  wire logic                         last,
    output int                                fail_count,
    output int                                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PRINTED = 40;
    localparam logic [11:0] TOP_VALUE = 12'd3999;

    // ASCII codes of the numeral symbols
    localparam logic [6:0] CH_NONE = 7'h00;
    localparam logic [6:0] CH_I    = 7'h49;
    localparam logic [6:0] CH_V    = 7'h56;
    localparam logic [6:0] CH_X    = 7'h58;
    localparam logic [6:0] CH_L    = 7'h4C;
    localparam logic [6:0] CH_C    = 7'h43;
    localparam logic [6:0] CH_D    = 7'h44;
    localparam logic [6:0] CH_M    = 7'h4D;

    // Role of a symbol within one decade
    typedef enum logic [1:0] {S_UNIT, S_HALF, S_NEXT} slot_t;

    typedef struct packed {
        logic [6:0] sym;
        logic       err;
        logic       fin;
    } roman_sym_t;

    roman_sym_t numeral_q[$];

    function automatic logic [6:0] decade_char(input int dec, input slot_t slot);
        logic [6:0] c;
        case (dec)
            0:       c = (slot == S_UNIT) ? CH_I : (slot == S_HALF) ? CH_V : CH_X;
            1:       c = (slot == S_UNIT) ? CH_X : (slot == S_HALF) ? CH_L : CH_C;
            2:       c = (slot == S_UNIT) ? CH_C : (slot == S_HALF) ? CH_D : CH_M;
            default: c = CH_M;
        endcase
        return c;
    endfunction

    // Expected symbol run for one accepted value
    task automatic push_numeral(input logic [11:0] v);
        int digit [4];
        int n;
        roman_sym_t run[$];
        roman_sym_t s;
        if (v == 12'd0 || v > TOP_VALUE)
        begin
            s.sym = CH_NONE;
            s.err = 1'b1;
            s.fin = 1'b1;
            numeral_q.push_back(s);
            return;
        end
        digit[3] = int'(v) / 1000;
        digit[2] = (int'(v) / 100) % 10;
        digit[1] = (int'(v) / 10) % 10;
        digit[0] = int'(v) % 10;
        s.err = 1'b0;
        s.fin = 1'b0;
        for (int dec = 3; dec >= 0; dec--)
        begin
            n = digit[dec];
            case (n)
                1, 2, 3:
                begin
                    for (int k = 0; k < n; k++)
                    begin
                        s.sym = decade_char(dec, S_UNIT);
                        run.push_back(s);
                    end
                end
                4:
                begin
                    s.sym = decade_char(dec, S_UNIT);
                    run.push_back(s);
                    s.sym = decade_char(dec, S_HALF);
                    run.push_back(s);
                end
                5, 6, 7, 8:
                begin
                    s.sym = decade_char(dec, S_HALF);
                    run.push_back(s);
                    for (int k = 5; k < n; k++)
                    begin
                        s.sym = decade_char(dec, S_UNIT);
                        run.push_back(s);
                    end
                end
                9:
                begin
                    s.sym = decade_char(dec, S_UNIT);
                    run.push_back(s);
                    s.sym = decade_char(dec, S_NEXT);
                    run.push_back(s);
                end
                default: ;
            endcase
        end
        run[run.size()-1].fin = 1'b1;
        foreach (run[i]) numeral_q.push_back(run[i]);
    endtask

    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_PRINTED)
            $display("%0t ns: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // Watch both channels at every edge
    always @(posedge clk)
    begin
        roman_sym_t exp_sym;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (numeral_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected symbol %h err %b last %b",
                                              symbol, error, last));
                end
                else
                begin
                    exp_sym = numeral_q.pop_front();
                    if (symbol !== exp_sym.sym)
                        report_mismatch($sformatf("symbol %h, wanted %h",
                                                  symbol, exp_sym.sym));
                    if (error !== exp_sym.err)
                        report_mismatch($sformatf("error %b, wanted %b",
                                                  error, exp_sym.err));
                    if (last !== exp_sym.fin)
                        report_mismatch($sformatf("last %b, wanted %b",
                                                  last, exp_sym.fin));
                end
            end
            if (in_valid && !in_stall)
                push_numeral(value);
        end
        pending <= numeral_q.size();
    end
endmodule
`default_nettype wire

// File: tb/tb_integer_to_roman_serializer_core.sv
`default_nettype none
module tb_integer_to_roman_serializer_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 52;
    localparam int SQUEEZE_ITEMS = 24;
    localparam int DRAIN_CYCLES = 30;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [i2r_pkg::VALUE_W-1:0] value = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [i2r_pkg::SYM_W-1:0]   symbol;
    logic                        error;
    logic                        last;
    logic                        squeeze = 1'b0;
    int                          fail_count;
    int                          pending;

    integer_to_roman_serializer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .symbol    (symbol),
        .error     (error),
        .last      (last)
    );

    roman_numeral_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .symbol     (symbol),
        .error      (error),
        .last       (last),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2_400_000;
        $display("Regression FAIL");
        $finish;
    end

    // Offer one value and hold it until it is taken
    task automatic send_value(input logic [11:0] v);
        in_valid <= 1'b1;
        value    <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            value    <= 12'($urandom);
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Mostly legal values, many built digit by digit, some out of range
    function automatic logic [11:0] pick_value();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 4)
            v = 0;
        else if (r < 12)
            v = $urandom_range(4000, 4095);
        else if (r < 60)
        begin
            v = $urandom_range(0, 3) * 1000 + $urandom_range(0, 9) * 100
                + $urandom_range(0, 9) * 10 + $urandom_range(0, 9);
            if (v == 0)
                v = 3888;
        end
        else
            v = $urandom_range(1, 3999);
        return 12'(v);
    endfunction

    // Receiver stall pattern, with one long hold-off on request
    initial
    begin
        int hold_left;
        int seg_left;
        int mode;
        int phase;
        bit held;
        hold_left = 0;
        seg_left  = 0;
        mode      = 0;
        phase     = 0;
        held      = 1'b0;
        forever
        begin
            @(posedge clk);
            if (squeeze && !held)
            begin
                hold_left = 300;
                held      = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode     = $urandom_range(0, 2);
                    seg_left = $urandom_range(5, 60);
                    phase    = 0;
                end
                seg_left--;
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= 1'($urandom_range(0, 1));
                    default: out_stall <= (phase % 3 == 2);
                endcase
                phase++;
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        logic [11:0] directed [$];
        int sent;
        int burst;
        directed = '{12'd0, 12'd1, 12'd3999, 12'd4000, 12'd4095, 12'd3888, 12'd4,
                     12'd9, 12'd40, 12'd90, 12'd400, 12'd900, 12'd1994, 12'd5,
                     12'd6, 12'd7, 12'd8, 12'd2, 12'd3, 12'd10, 12'd100, 12'd1000,
                     12'd3000, 12'd444, 12'd2048};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed values
        foreach (directed[i])
        begin
            send_value(directed[i]);
            if ($urandom_range(0, 3) == 0)
                idle_gap($urandom_range(1, 5));
        end
        wait_drained();

        // Back-to-back items against a long output hold-off
        squeeze <= 1'b1;
        for (int i = 0; i < SQUEEZE_ITEMS; i++)
            send_value(i[0] ? 12'd3888 : pick_value());
        squeeze <= 1'b0;
        wait_drained();

        // Random values in bursts
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++)
            begin
                send_value(pick_value());
                sent++;
            end
            if ($urandom_range(0, 4) != 0)
                idle_gap($urandom_range(1, 8));
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// File: integer_to_roman_serializer_core.f
+incdir+rtl
rtl/i2r_pkg.sv
rtl/i2r_front.sv
rtl/i2r_queue.sv
rtl/i2r_back.sv
rtl/integer_to_roman_serializer_core.sv
tb/roman_numeral_checker.sv
tb/tb_integer_to_roman_serializer_core.sv
